>>> design/etcl_pkg.sv
// shared types, class and event codes and byte constants for the token class lexer
// used by every module of the block; no dependencies of its own
package etcl_pkg;

    localparam int LINE_BITS = 16;
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

    // token classes
    localparam logic [4:0] C_WS      = 5'd0;
    localparam logic [4:0] C_SPECIAL = 5'd1;
    localparam logic [4:0] C_COMMENT = 5'd2;
    localparam logic [4:0] C_UINT    = 5'd3;
    localparam logic [4:0] C_SIGN    = 5'd4;
    localparam logic [4:0] C_INT     = 5'd5;
    localparam logic [4:0] C_POTREAL = 5'd6;
    localparam logic [4:0] C_REAL    = 5'd7;
    localparam logic [4:0] C_DATE    = 5'd8;
    localparam logic [4:0] C_QSTR    = 5'd9;
    localparam logic [4:0] C_STR     = 5'd10;
    localparam logic [4:0] C_KEYWORD = 5'd11;
    localparam logic [4:0] C_OPER    = 5'd12;
    localparam logic [4:0] C_POTLL   = 5'd13;
    localparam logic [4:0] C_LL      = 5'd14;
    localparam logic [4:0] C_EXP     = 5'd15;
    localparam logic [4:0] C_POTDG   = 5'd16;
    localparam logic [4:0] C_DG      = 5'd17;

    // event kinds
    localparam logic [1:0] EV_APPEND  = 2'd0;
    localparam logic [1:0] EV_EMIT    = 2'd1;
    localparam logic [1:0] EV_DISCARD = 2'd2;

    // input functions
    localparam logic FN_BYTE = 1'b0;
    localparam logic FN_END  = 1'b1;

    // bytes with rules of their own
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_LE    = 8'h65;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] chr;
        logic [4:0] cls;
    } t_event;

    // all events caused by one item, in order, and the line they carry
    typedef struct packed {
        logic [1:0]           cnt;
        t_event [2:0]         ev;
        logic [LINE_BITS-1:0] line;
    } t_batch;

endpackage

>>> design/etcl_core.sv
// lexer state (class, has-text flag, line count) and the per-item step logic
// depends on etcl_pkg; produces one event batch per accepted item
module etcl_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_func,
    input  logic [7:0]                    i_char_in,
    output etcl_pkg::t_batch              o_batch
);

    logic [4:0]                     r_class, n_class;
    logic                           r_has_text, n_has_text;
    logic [etcl_pkg::LINE_BITS-1:0] r_line, n_line;

    function automatic etcl_pkg::t_batch push(etcl_pkg::t_batch b, etcl_pkg::t_event e);
        etcl_pkg::t_batch r;
        r = b;
        r.ev[r.cnt] = e;
        r.cnt = r.cnt + 2'd1;
        return r;
    endfunction

    function automatic etcl_pkg::t_event mk_append(logic [7:0] c);
        etcl_pkg::t_event e;
        e.kind = etcl_pkg::EV_APPEND;
        e.chr  = c;
        e.cls  = etcl_pkg::C_WS;
        return e;
    endfunction

    // close the open token: comment or whitespace with text is discarded, other classes are emitted
    function automatic etcl_pkg::t_batch close_tok(etcl_pkg::t_batch b, logic [4:0] cls,
                                                   logic ht);
        etcl_pkg::t_event e;
        etcl_pkg::t_batch r;
        r      = b;
        e.chr  = 8'd0;
        e.cls  = 5'd0;
        e.kind = etcl_pkg::EV_DISCARD;
        if (cls == etcl_pkg::C_COMMENT) begin
            r = push(r, e);
        end else if (cls == etcl_pkg::C_WS) begin
            if (ht) r = push(r, e);
        end else begin
            e.kind = etcl_pkg::EV_EMIT;
            e.cls  = cls;
            r = push(r, e);
        end
        return r;
    endfunction

    logic             digit, letter;
    logic [4:0]       t;
    logic [7:0]       c;
    etcl_pkg::t_batch b;

    always_comb begin
        c      = i_char_in;
        t      = r_class;
        digit  = (c >= 8'h30) && (c <= 8'h39);
        letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
        n_class    = r_class;
        n_has_text = r_has_text;
        n_line     = r_line;
        b          = '0;
        b.line     = r_line;

        if (i_func == etcl_pkg::FN_END) begin
            b = close_tok(b, n_class, n_has_text);
            n_class    = etcl_pkg::C_WS;
            n_has_text = 1'b0;
            n_line     = etcl_pkg::LINE_ONE;
        end else if (c == etcl_pkg::CH_GT) begin
            if (t == etcl_pkg::C_WS) n_class = etcl_pkg::C_SPECIAL;
            b = push(b, mk_append(c));
            n_has_text = 1'b1;
        end else if (c == etcl_pkg::CH_BANG) begin
            if (t == etcl_pkg::C_SPECIAL) n_class = etcl_pkg::C_COMMENT;
            b = push(b, mk_append(c));
            n_has_text = 1'b1;
        end else if (digit) begin
            if (t == etcl_pkg::C_WS) n_class = etcl_pkg::C_UINT;
            else if (t == etcl_pkg::C_SIGN) n_class = etcl_pkg::C_INT;
            else if (t == etcl_pkg::C_POTREAL) n_class = etcl_pkg::C_REAL;
            b = push(b, mk_append(c));
            n_has_text = 1'b1;
        end else if (c == etcl_pkg::CH_QUOTE) begin
            if (t == etcl_pkg::C_WS) begin
                n_class = etcl_pkg::C_QSTR;
                b = push(b, mk_append(c));
                n_has_text = 1'b1;
            end else if (t == etcl_pkg::C_QSTR) begin
                b = push(b, mk_append(c));
                b = close_tok(b, n_class, 1'b1);
                n_class    = etcl_pkg::C_WS;
                n_has_text = 1'b0;
            end
        end else if (c == etcl_pkg::CH_DOT) begin
            if (t == etcl_pkg::C_WS) begin
                n_class = etcl_pkg::C_POTREAL;
                b = push(b, mk_append(c));
                n_has_text = 1'b1;
            end else if (t == etcl_pkg::C_INT || t == etcl_pkg::C_UINT) begin
                n_class = etcl_pkg::C_REAL;
                b = push(b, mk_append(c));
                n_has_text = 1'b1;
            end else if (t == etcl_pkg::C_STR || t == etcl_pkg::C_QSTR ||
                         t == etcl_pkg::C_KEYWORD) begin
                b = push(b, mk_append(c));
                n_has_text = 1'b1;
            end
        end else if (c == etcl_pkg::CH_EQ) begin
            if (t == etcl_pkg::C_SPECIAL) begin
                n_class = etcl_pkg::C_KEYWORD;
                b = push(b, mk_append(c));
                n_has_text = 1'b1;
            end else begin
                // close what is open, then a one-byte operator token
                b = close_tok(b, n_class, n_has_text);
                b = push(b, mk_append(c));
                b = close_tok(b, etcl_pkg::C_OPER, 1'b1);
                n_class    = etcl_pkg::C_WS;
                n_has_text = 1'b0;
            end
        end else if (c == etcl_pkg::CH_COLON) begin
            if (t == etcl_pkg::C_INT) n_class = etcl_pkg::C_POTLL;
            else if (t == etcl_pkg::C_POTLL) n_class = etcl_pkg::C_LL;
            b = push(b, mk_append(c));
            n_has_text = 1'b1;
        end else if (c == etcl_pkg::CH_UE || c == etcl_pkg::CH_LE) begin
            if (t == etcl_pkg::C_STR || t == etcl_pkg::C_WS) n_class = etcl_pkg::C_STR;
            else if (t == etcl_pkg::C_REAL) n_class = etcl_pkg::C_EXP;
            b = push(b, mk_append(c));
            n_has_text = 1'b1;
        end else if (letter) begin
            if (t == etcl_pkg::C_WS) n_class = etcl_pkg::C_STR;
            else if (t == etcl_pkg::C_SPECIAL) n_class = etcl_pkg::C_KEYWORD;
            b = push(b, mk_append(c));
            n_has_text = 1'b1;
        end else if (c == etcl_pkg::CH_PLUS || c == etcl_pkg::CH_MINUS) begin
            if (t == etcl_pkg::C_WS) n_class = etcl_pkg::C_SIGN;
            b = push(b, mk_append(c));
            n_has_text = 1'b1;
        end else if (c == etcl_pkg::CH_SLASH) begin
            if (t == etcl_pkg::C_INT || t == etcl_pkg::C_DATE || t == etcl_pkg::C_UINT) begin
                n_class = etcl_pkg::C_DATE;
                b = push(b, mk_append(c));
                n_has_text = 1'b1;
            end else if (t == etcl_pkg::C_WS) begin
                n_class = etcl_pkg::C_POTDG;
                b = push(b, mk_append(c));
                n_has_text = 1'b1;
            end else if (t == etcl_pkg::C_POTDG) begin
                b = push(b, mk_append(c));
                b = close_tok(b, etcl_pkg::C_DG, 1'b1);
                n_class    = etcl_pkg::C_WS;
                n_has_text = 1'b0;
            end else begin
                b = push(b, mk_append(c));
                n_has_text = 1'b1;
            end
        end else if (c == etcl_pkg::CH_SPACE || c == etcl_pkg::CH_TAB) begin
            if (t == etcl_pkg::C_COMMENT || t == etcl_pkg::C_QSTR) begin
                b = push(b, mk_append(c));
                n_has_text = 1'b1;
            end else begin
                // a lone sign closes as a string
                b = close_tok(b, (t == etcl_pkg::C_SIGN) ? etcl_pkg::C_STR : t, r_has_text);
                n_class    = etcl_pkg::C_WS;
                n_has_text = 1'b0;
            end
        end else if (c == etcl_pkg::CH_CR || c == etcl_pkg::CH_LF) begin
            b = close_tok(b, t, r_has_text);
            n_class    = etcl_pkg::C_WS;
            n_has_text = 1'b0;
            if (r_line != etcl_pkg::LINE_MAX) n_line = r_line + etcl_pkg::LINE_ONE;
        end else begin
            if (t == etcl_pkg::C_WS || t == etcl_pkg::C_INT || t == etcl_pkg::C_REAL ||
                t == etcl_pkg::C_SIGN) begin
                b = close_tok(b, (t == etcl_pkg::C_SIGN) ? etcl_pkg::C_STR : t, r_has_text);
                n_class    = etcl_pkg::C_WS;
                n_has_text = 1'b0;
            end
        end
    end

    assign o_batch = b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class    <= etcl_pkg::C_WS;
            r_has_text <= 1'b0;
            r_line     <= etcl_pkg::LINE_ONE;
        end else if (i_accept) begin
            r_class    <= n_class;
            r_has_text <= n_has_text;
            r_line     <= n_line;
        end
    end

endmodule

>>> design/etcl_evbuf.sv
// result register holding one item's events (up to three), drained one per cycle while not stalled
// depends on etcl_pkg for the batch type and event codes
module etcl_evbuf (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  etcl_pkg::t_batch               i_batch,
    input  logic                           i_stall,
    output logic                           o_ready,
    output logic                           o_valid,
    output logic [1:0]                     o_event_kind,
    output logic [7:0]                     o_char_out,
    output logic [4:0]                     o_token_class,
    output logic [etcl_pkg::LINE_BITS-1:0] o_line_out,
    output logic                           o_last
);

    logic [1:0]                     r_cnt;
    etcl_pkg::t_event [2:0]         r_ev;
    logic [etcl_pkg::LINE_BITS-1:0] r_line;
    logic                           take;

    assign o_valid = (r_cnt != 2'd0);
    assign take    = o_valid && !i_stall;
    // a new batch may enter once the last pending event leaves
    assign o_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && take);

    assign o_event_kind  = r_ev[0].kind;
    assign o_char_out    = r_ev[0].chr;
    assign o_token_class = r_ev[0].cls;
    assign o_line_out    = r_line;
    assign o_last        = (r_cnt == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ev   <= i_batch.ev;
            r_line <= i_batch.line;
        end else if (take) begin
            r_ev[0] <= r_ev[1];
            r_ev[1] <= r_ev[2];
        end
    end

endmodule

>>> design/edi_token_class_lexer.sv
// top level of the token class lexer: step logic and result register
// depends on etcl_pkg, etcl_core and etcl_evbuf
//
// Input channel (i_in_valid / o_in_stall): one item per accepted cycle, either a
// text byte (i_func = 0, byte on i_char_in) or end of text (i_func = 1).
// Output channel (o_out_valid / i_out_stall): one event per accepted cycle with
// kind, appended byte, token class, line number and a last flag that marks the
// final event of an item. An item may cause zero to three events.
// Latency: the first event of an item is shown the cycle after the item is
// accepted. Throughput: one item per cycle while each item causes at most one
// event and the receiver does not stall; an item with more events holds the
// input until its last event leaves the single result register, which drains
// one event a cycle while not stalled. Items with no event show nothing.
// A stalled receiver holds the current event; the input stalls once the result
// register cannot take the next item's events.
// Reset (synchronous, active low) sets whitespace class, no text, line one and
// empties the result register.
module edi_token_class_lexer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_func,
    input  logic [7:0]                     i_char_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_event_kind,
    output logic [7:0]                     o_char_out,
    output logic [4:0]                     o_token_class,
    output logic [etcl_pkg::LINE_BITS-1:0] o_line_out,
    output logic                           o_last
);

    logic             accept;
    logic             ready;
    etcl_pkg::t_batch batch;

    assign o_in_stall = !ready;
    assign accept     = i_in_valid && ready;

    etcl_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_func    (i_func),
        .i_char_in (i_char_in),
        .o_batch   (batch)
    );

    etcl_evbuf u_evbuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept),
        .i_batch       (batch),
        .i_stall       (i_out_stall),
        .o_ready       (ready),
        .o_valid       (o_out_valid),
        .o_event_kind  (o_event_kind),
        .o_char_out    (o_char_out),
        .o_token_class (o_token_class),
        .o_line_out    (o_line_out),
        .o_last        (o_last)
    );

endmodule

>>> tb/tb_edi_token_class_lexer.sv
// self-checking testbench for the token class lexer: directed and random byte streams,
// checked event by event against a predictor kept in the testbench
// depends on etcl_pkg and edi_token_class_lexer
module tb_edi_token_class_lexer;
    import etcl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 480;
    localparam int TAIL_CYCLES    = 10;
    localparam logic [4:0] NO_CLASS = 5'd0;
    localparam logic [7:0] NO_CHAR  = 8'h00;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           chr;
        logic [4:0]           cls;
        logic [LINE_BITS-1:0] line;
        logic                 last;
    } t_lex_event;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_func      = FN_BYTE;
    logic [7:0]           i_char_in   = 8'h00;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [1:0]           o_event_kind;
    logic [7:0]           o_char_out;
    logic [4:0]           o_token_class;
    logic [LINE_BITS-1:0] o_line_out;
    logic                 o_last;

    // lexer state as the testbench sees it
    logic [4:0]           tok_class    = C_WS;
    logic                 tok_has_text = 1'b0;
    logic [LINE_BITS-1:0] line_cnt     = LINE_ONE;
    t_lex_event           item_events[$];
    t_lex_event           expected_events[$];

    int mismatch_cnt = 0;
    int items_sent   = 0;
    int idle_cycles  = 0;
    int rx_hold      = 0;
    bit tx_gaps_on   = 1'b0;
    bit rx_gaps_on   = 1'b0;

    edi_token_class_lexer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_char_in    (i_char_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_char_out   (o_char_out),
        .o_token_class(o_token_class),
        .o_line_out   (o_line_out),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 80) return int'($urandom_range(1, 3));
        if (r < 95) return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic void note_event(input logic [1:0] kind, input logic [7:0] chr,
                                       input logic [4:0] cls);
        t_lex_event ev;
        ev = '{kind, chr, cls, line_cnt, 1'b0};
        item_events = {item_events, ev};
    endfunction

    function automatic void append_char(input logic [7:0] chr);
        note_event(EV_APPEND, chr, NO_CLASS);
        tok_has_text = 1'b1;
    endfunction

    function automatic void close_token();
        if (tok_class == C_COMMENT) begin
            note_event(EV_DISCARD, NO_CHAR, NO_CLASS);
        end else if (tok_class == C_WS) begin
            if (tok_has_text) note_event(EV_DISCARD, NO_CHAR, NO_CLASS);
        end else begin
            note_event(EV_EMIT, NO_CHAR, tok_class);
        end
        tok_class    = C_WS;
        tok_has_text = 1'b0;
    endfunction

    function automatic void lex_byte(input logic [7:0] c);
        logic [4:0] t;
        logic       digit;
        logic       letter;
        t      = tok_class;
        digit  = (c >= "0") && (c <= "9");
        letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        if (c == CH_GT) begin
            if (t == C_WS) tok_class = C_SPECIAL;
            append_char(c);
        end else if (c == CH_BANG) begin
            if (t == C_SPECIAL) tok_class = C_COMMENT;
            append_char(c);
        end else if (digit) begin
            if (t == C_WS) tok_class = C_UINT;
            else if (t == C_SIGN) tok_class = C_INT;
            else if (t == C_POTREAL) tok_class = C_REAL;
            append_char(c);
        end else if (c == CH_QUOTE) begin
            if (t == C_WS) begin
                tok_class = C_QSTR;
                append_char(c);
            end else if (t == C_QSTR) begin
                append_char(c);
                close_token();
            end
        end else if (c == CH_DOT) begin
            if (t == C_WS) begin
                tok_class = C_POTREAL;
                append_char(c);
            end else if (t == C_INT || t == C_UINT) begin
                tok_class = C_REAL;
                append_char(c);
            end else if (t == C_STR || t == C_QSTR || t == C_KEYWORD) begin
                append_char(c);
            end
        end else if (c == CH_EQ) begin
            if (t == C_SPECIAL) begin
                tok_class = C_KEYWORD;
                append_char(c);
            end else begin
                // operator is a token of its own: close, append, close
                close_token();
                tok_class = C_OPER;
                append_char(c);
                close_token();
            end
        end else if (c == CH_COLON) begin
            if (t == C_INT) tok_class = C_POTLL;
            else if (t == C_POTLL) tok_class = C_LL;
            append_char(c);
        end else if (c == CH_UE || c == CH_LE) begin
            if (t == C_STR || t == C_WS) tok_class = C_STR;
            else if (t == C_REAL) tok_class = C_EXP;
            append_char(c);
        end else if (letter) begin
            if (t == C_WS) tok_class = C_STR;
            else if (t == C_SPECIAL) tok_class = C_KEYWORD;
            append_char(c);
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            if (t == C_WS) tok_class = C_SIGN;
            append_char(c);
        end else if (c == CH_SLASH) begin
            if (t == C_INT || t == C_DATE || t == C_UINT) begin
                tok_class = C_DATE;
                append_char(c);
            end else if (t == C_WS) begin
                tok_class = C_POTDG;
                append_char(c);
            end else if (t == C_POTDG) begin
                tok_class = C_DG;
                append_char(c);
                close_token();
            end else begin
                append_char(c);
            end
        end else if (c == CH_SPACE || c == CH_TAB) begin
            if (t == C_COMMENT || t == C_QSTR) begin
                append_char(c);
            end else begin
                if (t == C_SIGN) tok_class = C_STR;
                close_token();
            end
        end else if (c == CH_CR || c == CH_LF) begin
            close_token();
            if (line_cnt != LINE_MAX) line_cnt = line_cnt + LINE_ONE;
        end else if (t == C_WS || t == C_INT || t == C_REAL) begin
            close_token();
        end else if (t == C_SIGN) begin
            tok_class = C_STR;
            close_token();
        end
    endfunction

    function automatic void predict_item(input logic fn, input logic [7:0] chr);
        item_events.delete();
        if (fn == FN_END) begin
            close_token();
            line_cnt = LINE_ONE;
        end else begin
            lex_byte(chr);
        end
        if (item_events.size() > 0) item_events[item_events.size() - 1].last = 1'b1;
        expected_events = {expected_events, item_events};
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic fn, input logic [7:0] chr);
        int gap;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 3) == 0) gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= fn;
        i_char_in  <= chr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_item(fn, chr);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_digits(input int n);
        repeat (n) send_item(FN_BYTE, 8'("0" + $urandom_range(0, 9)));
    endtask

    task automatic send_letters(input int n);
        repeat (n) send_item(FN_BYTE,
                             8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25)));
    endtask

    task automatic send_printable(input int n);
        repeat (n) send_item(FN_BYTE, 8'($urandom_range(32, 126)));
    endtask

    // comment, whitespace with text, bare whitespace, high bytes, cr lf pair
    task automatic test_close_rules();
        send_item(FN_BYTE, CH_GT);
        send_item(FN_BYTE, CH_BANG);
        send_item(FN_BYTE, 8'hFF);
        send_item(FN_BYTE, CH_SPACE);
        send_item(FN_BYTE, CH_CR);
        send_item(FN_BYTE, CH_LF);
        send_item(FN_BYTE, CH_BANG);
        send_item(FN_BYTE, 8'h00);
        send_item(FN_BYTE, 8'h00);
    endtask

    // open string closed by an operator gives three events
    task automatic test_max_events();
        send_item(FN_BYTE, "a");
        send_item(FN_BYTE, "b");
        send_item(FN_BYTE, CH_EQ);
    endtask

    task automatic test_end_of_text();
        send_item(FN_BYTE, "5");
        send_item(FN_END, 8'hFF);
        send_item(FN_BYTE, "7");
        send_item(FN_BYTE, CH_SPACE);
    endtask

    // tokens that close on their own last byte, and a lone sign
    task automatic test_self_closing();
        send_item(FN_BYTE, CH_QUOTE);
        send_item(FN_BYTE, CH_QUOTE);
        send_item(FN_BYTE, CH_SLASH);
        send_item(FN_BYTE, CH_SLASH);
        send_item(FN_BYTE, CH_MINUS);
        send_item(FN_BYTE, CH_SPACE);
    endtask

    // line breaks advance the line, end of text brings it back to one
    task automatic test_line_count();
        tx_gaps_on = 1'b0;
        repeat (5) send_item(FN_BYTE, CH_LF);
        send_item(FN_BYTE, "a");
        send_item(FN_BYTE, CH_CR);
        send_item(FN_BYTE, "b");
        send_item(FN_BYTE, CH_SPACE);
        send_item(FN_END, 8'h00);
        send_item(FN_BYTE, "c");
        send_item(FN_BYTE, CH_SPACE);
    endtask

    task automatic send_random_token();
        int n;
        n = int'($urandom_range(1, 4));
        case ($urandom_range(0, 13))
            0: send_digits(n);
            1: begin
                send_item(FN_BYTE, $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                send_digits(n);
            end
            2: begin
                send_digits(n);
                send_item(FN_BYTE, CH_DOT);
                send_digits(int'($urandom_range(1, 3)));
                if ($urandom_range(0, 1)) begin
                    send_item(FN_BYTE, $urandom_range(0, 1) ? CH_UE : CH_LE);
                    send_digits(int'($urandom_range(1, 2)));
                end
            end
            3: begin
                send_item(FN_BYTE, CH_DOT);
                send_digits(n);
            end
            4: begin
                send_digits(n);
                send_item(FN_BYTE, CH_SLASH);
                send_digits(2);
                send_item(FN_BYTE, CH_SLASH);
                send_digits(2);
            end
            5: begin
                send_item(FN_BYTE, $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                send_digits(n);
                send_item(FN_BYTE, CH_COLON);
                send_digits(2);
                send_item(FN_BYTE, CH_COLON);
                send_digits(2);
            end
            6: begin
                send_letters(n);
                if ($urandom_range(0, 2) == 0) begin
                    send_item(FN_BYTE, CH_DOT);
                    send_letters(2);
                end
            end
            7: begin
                send_item(FN_BYTE, CH_GT);
                send_letters(n);
                if ($urandom_range(0, 1)) send_item(FN_BYTE, CH_EQ);
            end
            8: begin
                send_item(FN_BYTE, CH_GT);
                send_item(FN_BYTE, CH_BANG);
                send_printable(n + 2);
            end
            9: begin
                send_item(FN_BYTE, CH_QUOTE);
                send_printable(n);
                send_item(FN_BYTE, CH_QUOTE);
            end
            10: begin
                send_item(FN_BYTE, CH_SLASH);
                if ($urandom_range(0, 2) != 0) send_item(FN_BYTE, CH_SLASH);
                else send_letters(1);
            end
            11: repeat (n) send_item(FN_BYTE, 8'($urandom_range(0, 255)));
            12: send_item(FN_BYTE, CH_EQ);
            default: send_item(FN_END, 8'($urandom_range(0, 255)));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: send_item(FN_BYTE, CH_SPACE);
            4: send_item(FN_BYTE, CH_TAB);
            5: send_item(FN_BYTE, CH_LF);
            6: send_item(FN_BYTE, CH_CR);
            7: send_item(FN_BYTE, CH_EQ);
            8: ;
            default: send_item(FN_BYTE, 8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic test_random_text();
        while (items_sent < RANDOM_ITEMS) begin
            // switch idling on and off in stretches
            if ($urandom_range(0, 15) == 0) begin
                tx_gaps_on = ($urandom_range(0, 2) != 0);
                rx_gaps_on = ($urandom_range(0, 2) != 0);
            end
            send_random_token();
        end
    endtask

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_out_stall <= 1'b1;
            rx_hold     <= rx_hold - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (rx_gaps_on && $urandom_range(0, 3) == 0) rx_hold <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_lex_event want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_events.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: expected no event, got kind %0d char %h class %0d line %0d last %0b",
                         $time, o_event_kind, o_char_out, o_token_class, o_line_out, o_last);
            end else begin
                want = expected_events.pop_front();
                if (o_event_kind !== want.kind || o_char_out !== want.chr ||
                    o_token_class !== want.cls || o_line_out !== want.line ||
                    o_last !== want.last) begin
                    mismatch_cnt++;
                    $write("%0t: expected kind %0d char %h class %0d line %0d last %0b,",
                           $time, want.kind, want.chr, want.cls, want.line, want.last);
                    $display(" got kind %0d char %h class %0d line %0d last %0b",
                             o_event_kind, o_char_out, o_token_class, o_line_out, o_last);
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n    <= 1'b1;
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        test_close_rules();
        test_max_events();
        test_end_of_text();
        test_self_closing();
        test_line_count();
        test_random_text();
        i_in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_events.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/etcl_pkg.sv
design/etcl_core.sv
design/etcl_evbuf.sv
design/edi_token_class_lexer.sv
tb/tb_edi_token_class_lexer.sv
